// File: rtl/core/clt_pkg.sv
// Shared types and constants for the command line tokenizer.
`default_nettype none

package clt_pkg;

  localparam int MAX_LINE = 256;
  // Highest byte offset reported; the offset stops counting there.
  localparam int POS_LIMIT_INT = (MAX_LINE - 1 > 255) ? 255 : (MAX_LINE - 1);
  localparam logic [7:0] PosLimit = POS_LIMIT_INT[7:0];

  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChComma   = 8'h2C;
  localparam logic [7:0] ChLBrack  = 8'h5B;
  localparam logic [7:0] ChRBrack  = 8'h5D;
  localparam logic [7:0] ChQuote   = 8'h22;
  localparam logic [7:0] ChNul     = 8'h00;
  localparam logic [7:0] ChCr      = 8'h0D;
  localparam logic [7:0] ChLf      = 8'h0A;

  localparam logic [1:0] KindStart = 2'd0;
  localparam logic [1:0] KindDone  = 2'd1;
  localparam logic [1:0] KindError = 2'd2;

  // One result item as held in the output queue.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] position;
    logic [7:0] param_count;
    logic       run_end;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/core/command_line_tokenizer_unit.sv
// Command line tokenizer: byte scanner with a four-entry result queue.
`default_nettype none

// Channel | Dir | tdata                         | tuser   | tlast
// in_     | in  | [7:0] char_code               | -       | -
// out_    | out | [7:0] position, [15:8] count  | [1:0] kind | run_end
//
// One byte sits in an input register and is scanned once the queue has room for
// two results; its zero, one or two results go to a four-entry queue.
// A byte can be taken every cycle while the queue has room for two results;
// only a line end with a pending comma yields two.
// Synchronous active-low reset clears the scanner state and empties the queue.
// A stalled output only blocks input once the queue is more than half full.
module command_line_tokenizer_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] char_code
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [7:0] position, [15:8] param_count
  output logic [1:0]       out_tuser,  // [1:0] kind
  output logic             out_tlast   // run_end
);

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_WORD    = 2'd1,
    MODE_QUOTE   = 2'd2,
    MODE_BRACKET = 2'd3
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic        comma_r, comma_nxt;
  logic [7:0]  pos_r, pos_nxt;
  logic [7:0]  cnt_r, cnt_nxt;

  logic        in_v_r;
  logic [7:0]  ch_r;

  clt_pkg::res_t q_mem [4];
  logic [1:0]  wptr_r, rptr_r;
  logic [2:0]  qcnt_r;

  logic        go, pop, term, sep_word, idle_like;
  logic [1:0]  push_n;
  clt_pkg::res_t r0, r1;
  logic [7:0]  cnt_inc, pos_inc;

  assign go        = in_v_r && (qcnt_r <= 3'd2);
  assign in_tready = !in_v_r || go;
  assign pop       = out_tvalid && out_tready;

  assign cnt_inc = (cnt_r == 8'hFF) ? cnt_r : cnt_r + 8'd1;
  assign pos_inc = (pos_r < clt_pkg::PosLimit) ? pos_r + 8'd1 : pos_r;

  assign term = (ch_r == clt_pkg::ChNul) || (ch_r == clt_pkg::ChCr) ||
                (ch_r == clt_pkg::ChLf);
  assign sep_word = (ch_r == clt_pkg::ChSpace) || (ch_r == clt_pkg::ChComma) ||
                    (ch_r == clt_pkg::ChLBrack);
  // A separator inside a word drops back to the between-parameters handling.
  assign idle_like = (mode_r == MODE_IDLE) || ((mode_r == MODE_WORD) && sep_word);

  always_comb begin
    mode_nxt  = mode_r;
    comma_nxt = comma_r;
    pos_nxt   = pos_inc;
    cnt_nxt   = cnt_r;
    push_n    = 2'd0;
    r0        = '{kind: clt_pkg::KindStart, position: pos_r, param_count: cnt_inc,
                  run_end: 1'b1};
    r1        = '{kind: clt_pkg::KindDone, position: pos_r, param_count: cnt_inc,
                  run_end: 1'b1};
    if (term) begin
      mode_nxt  = MODE_IDLE;
      comma_nxt = 1'b0;
      pos_nxt   = 8'd0;
      cnt_nxt   = 8'd0;
      if (mode_r == MODE_QUOTE) begin
        push_n = 2'd1;
        r0     = '{kind: clt_pkg::KindError, position: pos_r, param_count: 8'd0,
                   run_end: 1'b1};
      end else if ((mode_r == MODE_IDLE) && comma_r) begin
        // trailing comma: empty parameter, then the closing item
        push_n     = 2'd2;
        r0.run_end = 1'b0;
      end else begin
        push_n = 2'd1;
        r0     = '{kind: clt_pkg::KindDone, position: pos_r, param_count: cnt_r,
                   run_end: 1'b1};
      end
    end else if (idle_like) begin
      mode_nxt = MODE_IDLE;
      if (ch_r == clt_pkg::ChSpace) begin
        push_n = 2'd0;
      end else if ((ch_r == clt_pkg::ChComma) && !comma_r) begin
        comma_nxt = 1'b1;
      end else begin
        push_n    = 2'd1;
        cnt_nxt   = cnt_inc;
        comma_nxt = 1'b0;
        if (ch_r == clt_pkg::ChLBrack) begin
          mode_nxt = MODE_BRACKET;
        end else if (ch_r != clt_pkg::ChComma) begin
          mode_nxt = MODE_WORD;
        end
      end
    end else begin
      unique case (mode_r)
        MODE_WORD:    if (ch_r == clt_pkg::ChQuote) mode_nxt = MODE_QUOTE;
        MODE_QUOTE:   if (ch_r == clt_pkg::ChQuote) mode_nxt = MODE_WORD;
        MODE_BRACKET: if (ch_r == clt_pkg::ChRBrack) mode_nxt = MODE_IDLE;
        default:      mode_nxt = mode_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      mode_r  <= MODE_IDLE;
      comma_r <= 1'b0;
      pos_r   <= 8'd0;
      cnt_r   <= 8'd0;
      wptr_r  <= 2'd0;
      rptr_r  <= 2'd0;
      qcnt_r  <= 3'd0;
    end else begin
      if (in_tready) begin
        in_v_r <= in_tvalid;
      end
      if (go) begin
        mode_r  <= mode_nxt;
        comma_r <= comma_nxt;
        pos_r   <= pos_nxt;
        cnt_r   <= cnt_nxt;
        wptr_r  <= wptr_r + (go ? push_n : 2'd0);
      end
      if (pop) begin
        rptr_r <= rptr_r + 2'd1;
      end
      qcnt_r <= qcnt_r + {1'b0, (go ? push_n : 2'd0)} - {2'b00, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      ch_r <= in_tdata;
    end
    if (go && (push_n != 2'd0)) begin
      q_mem[wptr_r] <= r0;
    end
    if (go && (push_n == 2'd2)) begin
      q_mem[wptr_r + 2'd1] <= r1;
    end
  end

  assign out_tvalid = (qcnt_r != 3'd0);
  assign out_tdata  = {q_mem[rptr_r].param_count, q_mem[rptr_r].position};
  assign out_tuser  = q_mem[rptr_r].kind;
  assign out_tlast  = q_mem[rptr_r].run_end;

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qcnt_r <= 3'd4) else $error("result queue overfilled");

  a_line_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    go && term |=> (pos_r == 8'd0) && (cnt_r == 8'd0) && (mode_r == MODE_IDLE) && !comma_r)
    else $error("state not cleared after line end");

  a_pair_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    go && (push_n == 2'd2) |-> term && !comma_nxt)
    else $error("two results from a byte that does not end the line");

  a_pos_limit: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= clt_pkg::PosLimit) else $error("offset beyond limit");

endmodule

`default_nettype wire

// File: test/tb.sv
// Self-checking testbench for the command line tokenizer: byte stream in, token marks out.
`timescale 1ns / 1ps

module tb;

  localparam int RANDOM_BYTES = 1730;
  localparam int CALM_TAIL    = 200;
  localparam int DRAIN_CYCLES = 50;
  localparam int CYCLE_LIMIT  = 400000;

  typedef enum logic [1:0] {SCAN_IDLE, SCAN_WORD, SCAN_QUOTE, SCAN_BRACKET} scan_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  // Line bytes still to send, and token marks still to arrive.
  logic [7:0]    line_bytes[$];
  clt_pkg::res_t expected_tokens[$];
  clt_pkg::res_t step_results[$];

  // Tokenizer state as predicted.
  scan_t      scan_mode = SCAN_IDLE;
  logic       comma_seen = 1'b0;
  logic [7:0] byte_pos = 8'd0;
  logic [7:0] token_cnt = 8'd0;

  int  mismatches = 0;
  int  cycle_count = 0;
  int  noise_pct = 0;
  int  gap_odds = 10;
  int  stall_odds = 10;
  int  send_gap = 0;
  int  hold_gap = 0;
  bit  byte_taken = 1'b0;
  bit  calm = 1'b0;

  command_line_tokenizer_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  function automatic clt_pkg::res_t token_result(logic [1:0] kind, logic [7:0] pos,
                                                 logic [7:0] cnt);
    clt_pkg::res_t r;
    r.kind        = kind;
    r.position    = pos;
    r.param_count = cnt;
    r.run_end     = 1'b0;
    return r;
  endfunction

  // Byte seen while between parameters.
  task automatic take_between(input logic [7:0] ch);
    if (ch == clt_pkg::ChComma && !comma_seen) begin
      comma_seen = 1'b1;
    end else if (ch != clt_pkg::ChSpace) begin
      if (token_cnt != 8'hFF) token_cnt++;
      step_results.push_back(token_result(clt_pkg::KindStart, byte_pos, token_cnt));
      if (ch == clt_pkg::ChLBrack) begin
        scan_mode = SCAN_BRACKET;
      end else if (ch != clt_pkg::ChComma) begin
        scan_mode = SCAN_WORD;
      end
      comma_seen = 1'b0;
    end
  endtask

  task automatic tokenize_byte(input logic [7:0] ch);
    clt_pkg::res_t r;
    step_results.delete();
    if (ch == clt_pkg::ChNul || ch == clt_pkg::ChCr || ch == clt_pkg::ChLf) begin
      if (scan_mode == SCAN_QUOTE) begin
        step_results.push_back(token_result(clt_pkg::KindError, byte_pos, 8'd0));
      end else begin
        // a comma still pending gives an empty parameter at the line end
        if (scan_mode == SCAN_IDLE && comma_seen) begin
          if (token_cnt != 8'hFF) token_cnt++;
          step_results.push_back(token_result(clt_pkg::KindStart, byte_pos, token_cnt));
        end
        step_results.push_back(token_result(clt_pkg::KindDone, byte_pos, token_cnt));
      end
      scan_mode  = SCAN_IDLE;
      comma_seen = 1'b0;
      byte_pos   = 8'd0;
      token_cnt  = 8'd0;
    end else begin
      case (scan_mode)
        SCAN_WORD: begin
          if (ch == clt_pkg::ChSpace || ch == clt_pkg::ChComma ||
              ch == clt_pkg::ChLBrack) begin
            scan_mode = SCAN_IDLE;
            take_between(ch);
          end else if (ch == clt_pkg::ChQuote) begin
            scan_mode = SCAN_QUOTE;
          end
        end
        SCAN_QUOTE: begin
          if (ch == clt_pkg::ChQuote) scan_mode = SCAN_WORD;
        end
        SCAN_BRACKET: begin
          if (ch == clt_pkg::ChRBrack) scan_mode = SCAN_IDLE;
        end
        default: begin
          take_between(ch);
        end
      endcase
      if (byte_pos < clt_pkg::PosLimit) byte_pos++;
    end
    for (int i = 0; i < step_results.size(); i++) begin
      r = step_results[i];
      r.run_end = (i == step_results.size() - 1);
      expected_tokens.push_back(r);
    end
  endtask

  // ---- stimulus helpers ----
  task automatic put_char(input logic [7:0] ch);
    if ($urandom_range(0, 99) < noise_pct) begin
      line_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      line_bytes.push_back(ch);
    end
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] ch;
    ch = 8'($urandom_range(33, 255));
    if (ch == clt_pkg::ChQuote || ch == clt_pkg::ChComma ||
        ch == clt_pkg::ChLBrack || ch == clt_pkg::ChRBrack) ch = "k";
    return ch;
  endfunction

  function automatic logic [7:0] filler_char();
    logic [7:0] ch;
    case ($urandom_range(0, 3))
      0: ch = clt_pkg::ChSpace;
      1: ch = clt_pkg::ChComma;
      2: ch = clt_pkg::ChLBrack;
      default: ch = plain_char();
    endcase
    return ch;
  endfunction

  task automatic add_word();
    repeat ($urandom_range(1, 5)) put_char(plain_char());
  endtask

  task automatic add_gap();
    case ($urandom_range(0, 5))
      0: repeat ($urandom_range(1, 3)) put_char(clt_pkg::ChSpace);
      1: push_text(",");
      2: push_text(", ");
      3: push_text(",,");
      4: push_text(", ,");
      default: push_text(" , ");
    endcase
  endtask

  task automatic add_line();
    int n_tok;
    logic [7:0] ending;
    n_tok = $urandom_range(0, 6);
    if ($urandom_range(0, 4) == 0) add_gap();
    for (int i = 0; i < n_tok; i++) begin
      if (i > 0) add_gap();
      case ($urandom_range(0, 4))
        0, 1: add_word();
        2: begin
          add_word();
          put_char(clt_pkg::ChQuote);
          repeat ($urandom_range(0, 4)) put_char(filler_char());
          put_char(clt_pkg::ChQuote);
          if ($urandom_range(0, 1)) add_word();
        end
        3: begin
          put_char(clt_pkg::ChLBrack);
          repeat ($urandom_range(0, 4)) put_char(filler_char());
          put_char(clt_pkg::ChRBrack);
          // text glued to the bracket opens a new parameter
          if ($urandom_range(0, 1)) add_word();
        end
        default: begin
          put_char(clt_pkg::ChQuote);
          add_word();
        end
      endcase
    end
    case ($urandom_range(0, 9))
      0: put_char(clt_pkg::ChComma);
      1: begin
        add_word();
        put_char(clt_pkg::ChQuote);
        add_word();
      end
      2: begin
        put_char(clt_pkg::ChSpace);
        put_char(clt_pkg::ChLBrack);
        add_word();
      end
      default: ;
    endcase
    case ($urandom_range(0, 2))
      0: ending = clt_pkg::ChNul;
      1: ending = clt_pkg::ChCr;
      default: ending = clt_pkg::ChLf;
    endcase
    put_char(ending);
  endtask

  function automatic int pick_odds();
    int odds;
    case ($urandom_range(0, 3))
      0: odds = 0;
      1: odds = 4;
      2: odds = 15;
      default: odds = 40;
    endcase
    return odds;
  endfunction

  // ---- input side ----
  always @(negedge clk) begin : byte_driver
    logic       nxt_valid;
    logic [7:0] nxt_byte;
    nxt_valid = in_tvalid;
    nxt_byte  = in_tdata;
    if (cycle_count[7:0] == 8'd0) gap_odds = pick_odds();
    if (rst_n && (!in_tvalid || byte_taken)) begin
      nxt_valid = 1'b0;
      if (calm) send_gap = 0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (line_bytes.size() != 0) begin
        if (!calm && $urandom_range(0, 99) < gap_odds) begin
          send_gap = $urandom_range(0, 18);
        end else begin
          nxt_valid = 1'b1;
          nxt_byte  = line_bytes.pop_front();
        end
      end
    end
    in_tvalid <= nxt_valid;
    in_tdata  <= nxt_byte;
  end

  // ---- output side ----
  always @(negedge clk) begin : ready_driver
    logic nxt_ready;
    nxt_ready = 1'b1;
    if (cycle_count[6:0] == 7'd3) stall_odds = pick_odds();
    if (!rst_n) begin
      nxt_ready = 1'b0;
    end else if (calm) begin
      hold_gap = 0;
    end else if (hold_gap > 0) begin
      hold_gap--;
      nxt_ready = 1'b0;
    end else if ($urandom_range(0, 99) < stall_odds) begin
      hold_gap = $urandom_range(0, 18);
      nxt_ready = 1'b0;
    end
    out_tready <= nxt_ready;
  end

  always @(posedge clk) begin : scoreboard
    clt_pkg::res_t seen;
    clt_pkg::res_t want;
    calm       = line_bytes.size() < CALM_TAIL;
    byte_taken = in_tvalid && in_tready;
    if (byte_taken) tokenize_byte(in_tdata);
    if (out_tvalid && out_tready) begin
      seen.kind        = out_tuser;
      seen.position    = out_tdata[7:0];
      seen.param_count = out_tdata[15:8];
      seen.run_end     = out_tlast;
      if (expected_tokens.size() == 0) begin
        if (mismatches < 10) begin
          $display("unexpected item: kind %0d pos %0d count %0d last %0b",
                   seen.kind, seen.position, seen.param_count, seen.run_end);
        end
        mismatches++;
      end else begin
        want = expected_tokens.pop_front();
        if (want.kind !== seen.kind || want.position !== seen.position ||
            want.param_count !== seen.param_count || want.run_end !== seen.run_end) begin
          if (mismatches < 10) begin
            $display("mismatch: want kind %0d pos %0d count %0d last %0b, %s",
                     want.kind, want.position, want.param_count, want.run_end,
                     $sformatf("got kind %0d pos %0d count %0d last %0b",
                               seen.kind, seen.position, seen.param_count,
                               seen.run_end));
          end
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    bit long_done;
    long_done = 1'b0;

    // directed lines: quote as first byte, glued bracket, trailing comma,
    // open quote, open bracket, byte extremes, double comma, empty line
    noise_pct = 0;
    push_text("\"a, [x]y,");
    put_char(clt_pkg::ChNul);
    push_text("a\"b");
    put_char(clt_pkg::ChCr);
    push_text("[z");
    put_char(clt_pkg::ChLf);
    put_char(8'hFF);
    put_char(8'h01);
    push_text(" ,,");
    put_char(clt_pkg::ChLf);
    put_char(clt_pkg::ChLf);

    while (line_bytes.size() < RANDOM_BYTES) begin
      if (!long_done && line_bytes.size() > 700) begin
        // long enough to saturate both offset and count
        noise_pct = 0;
        repeat (270) begin
          put_char(plain_char());
          put_char(clt_pkg::ChSpace);
        end
        put_char(clt_pkg::ChLf);
        long_done = 1'b1;
      end else begin
        noise_pct = ($urandom_range(0, 3) == 0) ? 25 : 2;
        add_line();
      end
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (line_bytes.size() != 0 || in_tvalid || expected_tokens.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/clt_pkg.sv
rtl/core/command_line_tokenizer_unit.sv
test/tb.sv
